FILE: rtl/lus_pkg.sv
// Shared types and constants for the largest uniform square stream block.
package lus_pkg;

  localparam int SIDE_W    = 11;
  localparam int ENTRY_W   = SIDE_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_DAT_W-1:0] DIM_RESET = 11'd1024;
  localparam logic [SIDE_W-1:0]    SIDE_MAX  = 11'h7FF;

  typedef struct packed {
    logic              color;
    logic [SIDE_W-1:0] side;
  } entry_t;

  // side a neighbor contributes to a pixel of the given color
  function automatic logic [SIDE_W-1:0] nb_side(entry_t e, logic color);
    logic [SIDE_W-1:0] s;
    s = (e.color == color) ? e.side : '0;
    return s;
  endfunction

endpackage

FILE: rtl/lus_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module lus_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/largest_uniform_square_stream.sv
// Top level: streaming largest uniform square over a binary raster image.
//
// Input channel: one pixel word per accepted cycle (in_valid high, in_stall
// low), raster order. Output channel: one word per pixel carrying the side
// of the largest same-colored square ending there, the best side of the
// frame so far and a flag on the last pixel of the frame.
// Configuration: cfg_index 0 writes image width, 1 writes image height;
// cfg_ready is always high. Write only while no pixel is in flight.
// A pixel's word is held in the compute stage, then in the output register.
// Throughput: one pixel per cycle while out_stall is low; the line buffer
// RAM is read when a pixel is accepted and written when it leaves the
// compute stage, the write forwarded when a one-pixel-wide image rereads it.
// Reset: counters, neighbor registers and best side clear, width and height
// return to 1024; the line buffer needs no clearing since row 0 ignores it.
// Output stall: the result register holds, the compute stage holds behind it
// and if it holds a pixel, in_stall rises combinationally in the same cycle.
module largest_uniform_square_stream #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_pixel_bit,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lus_pkg::SIDE_W-1:0]     out_side_here,
  output logic [lus_pkg::SIDE_W-1:0]     out_best_side,
  output logic                           out_frame_done,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lus_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lus_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import lus_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int DW0  = ((CW > RW) ? CW : RW) + 1;
  localparam int DW   = (DW0 > CFG_DAT_W) ? DW0 : CFG_DAT_W;
  localparam logic [DW-1:0] MAXW_D = DW'(MAX_WIDTH);
  localparam logic [DW-1:0] MAXH_D = DW'(MAX_HEIGHT);
  localparam logic [DW-1:0] ONE_D  = DW'(1);

  // configuration
  logic [CFG_DAT_W-1:0] width_r, height_r;
  logic [DW-1:0]        w_eff, h_eff, width_d, height_d;

  // input-side counters
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          last_col, last_row, in_acc;

  // compute stage
  logic          s1_v_r, s1_adv;
  logic          s1_pix_r, s1_col0_r, s1_row0_r, s1_lastc_r, s1_lastr_r;
  logic [CW-1:0] s1_col_r;
  logic          fwd_v_r;
  entry_t        fwd_d_r;
  entry_t        rd_data, up_entry, here;
  entry_t        left_r, left_nxt, diag_r, diag_nxt;
  logic [SIDE_W-1:0] best_r, best_nxt, best_out;
  logic [SIDE_W-1:0] up_s, left_s, diag_s, m_ul, m_all, side;

  // output register
  logic              out_v_r;
  logic [SIDE_W-1:0] out_side_r, out_best_r;
  logic              out_done_r;

  assign cfg_ready = 1'b1;

  assign width_d  = DW'(width_r);
  assign height_d = DW'(height_r);
  assign w_eff = (width_d == '0) ? ONE_D : ((width_d > MAXW_D) ? MAXW_D : width_d);
  assign h_eff = (height_d == '0) ? ONE_D : ((height_d > MAXH_D) ? MAXH_D : height_d);

  assign last_col = (DW'(col_r) + ONE_D) >= w_eff;
  assign last_row = (DW'(row_r) + ONE_D) >= h_eff;

  assign s1_adv   = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  lus_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (here),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (rd_data)
  );

  always_comb begin
    up_entry = s1_row0_r ? entry_t'('0) : (fwd_v_r ? fwd_d_r : rd_data);
    up_s     = nb_side(up_entry, s1_pix_r);
    left_s   = s1_col0_r ? '0 : nb_side(left_r, s1_pix_r);
    diag_s   = (s1_col0_r || s1_row0_r) ? '0 : nb_side(diag_r, s1_pix_r);
    m_ul     = (left_s < up_s) ? left_s : up_s;
    m_all    = (diag_s < m_ul) ? diag_s : m_ul;
    side     = (m_all == SIDE_MAX) ? m_all : m_all + SIDE_W'(1);
    here.color = s1_pix_r;
    here.side  = side;
    best_out = (side > best_r) ? side : best_r;
    best_nxt = best_r;
    left_nxt = left_r;
    diag_nxt = diag_r;
    if (s1_adv) begin
      best_nxt = (s1_lastc_r && s1_lastr_r) ? '0 : best_out;
      left_nxt = s1_lastc_r ? entry_t'('0) : here;
      diag_nxt = s1_lastc_r ? entry_t'('0) : up_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
      col_r    <= '0;
      row_r    <= '0;
      s1_v_r   <= 1'b0;
      left_r   <= '0;
      diag_r   <= '0;
      best_r   <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IMAGE_WIDTH) begin
          width_r <= cfg_data;
        end else if (cfg_index == REG_IMAGE_HEIGHT) begin
          height_r <= cfg_data;
        end
      end
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      left_r <= left_nxt;
      diag_r <= diag_nxt;
      best_r <= best_nxt;
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r   <= in_pixel_bit;
      s1_col_r   <= col_r;
      s1_col0_r  <= (col_r == '0);
      s1_row0_r  <= (row_r == '0);
      s1_lastc_r <= last_col;
      s1_lastr_r <= last_row;
      fwd_v_r    <= s1_adv && (s1_col_r == col_r);
      fwd_d_r    <= here;
    end
    if (s1_adv) begin
      out_side_r <= side;
      out_best_r <= best_out;
      out_done_r <= s1_lastc_r && s1_lastr_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_side_here  = out_side_r;
  assign out_best_side  = out_best_r;
  assign out_frame_done = out_done_r;

endmodule

FILE: rtl/lus_checker.sv
// Port-level checks for the largest uniform square stream block.
module lus_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [lus_pkg::SIDE_W-1:0] out_side_here,
  input logic [lus_pkg::SIDE_W-1:0] out_best_side,
  input logic                       out_frame_done
);
  import lus_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_side_here)
      && $stable(out_best_side) && $stable(out_frame_done))
    else $error("output word changed while stalled");

  a_best_ge_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_best_side >= out_side_here)
    else $error("best side below current side");

  a_side_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_side_here != '0)
    else $error("zero side reported");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind largest_uniform_square_stream lus_checker u_lus_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_side_here  (out_side_here),
  .out_best_side  (out_best_side),
  .out_frame_done (out_frame_done)
);
